>>> design/pts_pkg.sv
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared constants, types and codes for the scheduler block.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int LEN_W      = $clog2(TASK_SLOTS + 1);

   localparam logic [SLOT_W-1:0] IDLE_SLOT = '0;
   localparam logic [7:0] IDLE_PRIO_RESET = 8'd100;

   // Item kinds.
   localparam logic [2:0] KIND_CREATE = 3'd0;
   localparam logic [2:0] KIND_RUN    = 3'd1;
   localparam logic [2:0] KIND_DELAY  = 3'd2;
   localparam logic [2:0] KIND_TICK   = 3'd3;
   localparam logic [2:0] KIND_ISR_IN = 3'd4;
   localparam logic [2:0] KIND_ISR_EX = 3'd5;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT = 2'd1;
   localparam logic [1:0] STAT_BADPRIO = 2'd2;
   localparam logic [1:0] STAT_IDLEDLY = 2'd3;

   // Slot states.
   localparam logic [1:0] SS_FREE    = 2'd0;
   localparam logic [1:0] SS_READY   = 2'd1;
   localparam logic [1:0] SS_DELAYED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CREATE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_SHIFT,
      ST_DLY_SHIFT,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_TICK_INS,
      ST_SCHED,
      ST_DONE
   } state_type;

   // Slot table write request toward the slot memory.
   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] addr;
      logic [1:0]        st;
      logic [7:0]        prio;
      logic [15:0]       dly;
   } slot_wr_type;

endpackage

>>> design/priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Priority task scheduler unit
// Ready and delayed lists with a sequencer working over a slot memory.
// ----------------------------------------------------------------------------
// One item is taken at a time while busy is low; its word appears on the rsp_
// ports for one cycle with rsp_valid, and the receiver cannot stall it. A
// control item keeps busy high through ST_DONE, or through ST_SCHED and then
// ST_DONE when it reschedules, and its word follows in the next cycle. Create
// and insertion walk the ready list with a memory read, then a compare, for
// each entry passed, and then shift the list one entry a cycle; a delay shifts
// both lists one entry a cycle; a tick reads each delayed slot from the slot
// memory in turn (ST_TICK_RD, then ST_TICK_CHK), then for each expired task
// fetches its priority in ST_TICK_INS and runs an insertion walk. The slot
// memory's single read port sets this pace. The slot table is initialized by a
// pass over all TASK_SLOTS entries after reset, during which busy stays high.
// ----------------------------------------------------------------------------
module priority_task_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_delay_ticks,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_idle_priority,
   output logic        rsp_valid,
   output logic        rsp_current_valid,
   output logic [3:0]  rsp_current_task,
   output logic        rsp_switched,
   output logic [3:0]  rsp_new_task_slot,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_switch_count,
   output logic [31:0] rsp_tick_count
);
   import pts_pkg::*;

   state_type state_ff, state_in;

   logic [SLOT_W-1:0] rdy_ff [TASK_SLOTS];
   logic [SLOT_W-1:0] rdy_in [TASK_SLOTS];
   logic [SLOT_W-1:0] dly_ff [TASK_SLOTS];
   logic [SLOT_W-1:0] dly_in [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] used_ff, used_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in, dlen_ff, dlen_in;
   logic [LEN_W-1:0]  idx_ff, idx_in, wr_ff, wr_in;
   logic [SLOT_W-1:0] tgt_ff, tgt_in;
   logic [7:0]        tprio_ff, tprio_in;
   logic [7:0]        idle_ff;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic              runv_ff, runv_in, started_ff, started_in;
   logic [7:0]        nest_ff, nest_in;
   logic [31:0]       sw_cnt_ff, sw_cnt_in, tick_ff, tick_in;
   logic [2:0]        kind_ff, kind_in;
   logic [15:0]       dreq_ff, dreq_in;
   logic              swd_ff, swd_in;
   logic [SLOT_W-1:0] nslot_ff, nslot_in;
   logic [1:0]        stat_ff, stat_in;
   logic              init_ff;
   logic [SLOT_W-1:0] init_cnt_ff;
   logic              sched_q_ff, sched_q_in;
   logic [SLOT_W-1:0] exp_ff [TASK_SLOTS];
   logic [SLOT_W-1:0] exp_in [TASK_SLOTS];
   logic [LEN_W-1:0]  ne_ff, ne_in;
   logic              rv_ff, rv_in;

   slot_wr_type       wr;
   logic [SLOT_W-1:0] rd_addr;
   logic [25:0]       rd_data;
   logic [1:0]        rd_st;
   logic [7:0]        rd_prio;
   logic [15:0]       rd_dly;
   logic [SLOT_W-1:0] free_slot;
   logic              free_found;

   assign rd_st   = rd_data[25:24];
   assign rd_prio = rd_data[23:16];
   assign rd_dly  = rd_data[15:0];

   pts_slot_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE) || init_ff;
   assign csr_ready = !busy;

   // Lowest free slot above the idle slot.
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
         if (!used_ff[i]) begin
            free_slot  = SLOT_W'(i);
            free_found = 1'b1;
         end
      end
   end

   // Clearing pass counter and idle priority register.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b1;
         init_cnt_ff <= '0;
         idle_ff     <= IDLE_PRIO_RESET;
      end else begin
         if (init_ff) begin
            init_cnt_ff <= init_cnt_ff + 1'b1;
            if (init_cnt_ff == SLOT_W'(TASK_SLOTS - 1)) init_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) idle_ff <= csr_idle_priority;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= TASK_SLOTS'(1);
         rlen_ff    <= LEN_W'(1);
         dlen_ff    <= '0;
         runv_ff    <= 1'b0;
         run_ff     <= '0;
         started_ff <= 1'b0;
         nest_ff    <= '0;
         sw_cnt_ff  <= '0;
         tick_ff    <= '0;
         rv_ff      <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) rdy_ff[i] <= '0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         rlen_ff    <= rlen_in;
         dlen_ff    <= dlen_in;
         runv_ff    <= runv_in;
         run_ff     <= run_in;
         started_ff <= started_in;
         nest_ff    <= nest_in;
         sw_cnt_ff  <= sw_cnt_in;
         tick_ff    <= tick_in;
         rv_ff      <= rv_in;
         rdy_ff     <= rdy_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      dly_ff     <= dly_in;
      exp_ff     <= exp_in;
      ne_ff      <= ne_in;
      idx_ff     <= idx_in;
      wr_ff      <= wr_in;
      tgt_ff     <= tgt_in;
      tprio_ff   <= tprio_in;
      kind_ff    <= kind_in;
      dreq_ff    <= dreq_in;
      swd_ff     <= swd_in;
      nslot_ff   <= nslot_in;
      stat_ff    <= stat_in;
      sched_q_ff <= sched_q_in;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      rdy_in     = rdy_ff;
      dly_in     = dly_ff;
      exp_in     = exp_ff;
      ne_in      = ne_ff;
      used_in    = used_ff;
      rlen_in    = rlen_ff;
      dlen_in    = dlen_ff;
      idx_in     = idx_ff;
      wr_in      = wr_ff;
      tgt_in     = tgt_ff;
      tprio_in   = tprio_ff;
      run_in     = run_ff;
      runv_in    = runv_ff;
      started_in = started_ff;
      nest_in    = nest_ff;
      sw_cnt_in  = sw_cnt_ff;
      tick_in    = tick_ff;
      kind_in    = kind_ff;
      dreq_in    = dreq_ff;
      swd_in     = swd_ff;
      nslot_in   = nslot_ff;
      stat_in    = stat_ff;
      sched_q_in = sched_q_ff;
      rv_in      = 1'b0;
      wr         = '0;
      rd_addr    = rdy_ff[idx_ff[SLOT_W-1:0]];
      if (init_ff) begin
         wr.we   = 1'b1;
         wr.addr = init_cnt_ff;
         wr.st   = (init_cnt_ff == IDLE_SLOT) ? SS_READY : SS_FREE;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               kind_in    = req_kind;
               dreq_in    = (req_delay_ticks == 16'd0) ? 16'd1 : req_delay_ticks;
               swd_in     = 1'b0;
               nslot_in   = '0;
               stat_in    = STAT_OK;
               sched_q_in = 1'b0;
               tprio_in   = req_priority_req;
               state_in   = ST_DONE;
               unique case (req_kind)
                  KIND_CREATE: begin
                     if (req_priority_req >= idle_ff) stat_in = STAT_BADPRIO;
                     else if (!free_found) stat_in = STAT_NO_SLOT;
                     else begin
                        tgt_in     = free_slot;
                        nslot_in   = free_slot;
                        sched_q_in = 1'b1;
                        state_in   = ST_CREATE;
                     end
                  end
                  KIND_RUN: begin
                     started_in = 1'b1;
                     state_in   = ST_SCHED;
                  end
                  KIND_DELAY: begin
                     if (rlen_ff <= LEN_W'(1) || rdy_ff[0] == IDLE_SLOT)
                        stat_in = STAT_IDLEDLY;
                     else begin
                        tgt_in   = rdy_ff[0];
                        idx_in   = '0;
                        state_in = ST_DLY_SHIFT;
                     end
                  end
                  KIND_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     idx_in   = '0;
                     wr_in    = '0;
                     ne_in    = '0;
                     state_in = (dlen_ff == '0) ? ST_DONE : ST_TICK_RD;
                  end
                  KIND_ISR_IN: begin
                     if (nest_ff != 8'd255) nest_in = nest_ff + 8'd1;
                  end
                  KIND_ISR_EX: begin
                     if (nest_ff != 8'd0) begin
                        nest_in = nest_ff - 8'd1;
                        if (nest_ff == 8'd1) state_in = ST_SCHED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CREATE: begin
            wr.we   = 1'b1;
            wr.addr = tgt_ff;
            wr.st   = SS_READY;
            wr.prio = tprio_ff;
            wr.dly  = '0;
            used_in[tgt_ff] = 1'b1;
            idx_in   = '0;
            state_in = ST_INS_RD;
         end
         ST_INS_RD: begin
            // An expired task's priority arrives from the read issued just before.
            if (kind_ff == KIND_TICK && idx_ff == '0) tprio_in = rd_prio;
            // Last entry is idle tail; stop there.
            if (idx_ff + LEN_W'(1) >= rlen_ff) begin
               wr_in    = rlen_ff;
               state_in = ST_INS_SHIFT;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // Idle entry compares against the live register value.
            if (((rdy_ff[idx_ff[SLOT_W-1:0]] == IDLE_SLOT) ? idle_ff : rd_prio)
                >= tprio_ff) begin
               wr_in    = rlen_ff;
               state_in = ST_INS_SHIFT;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_INS_RD;
            end
         end
         ST_INS_SHIFT: begin
            if (wr_ff == idx_ff) begin
               rdy_in[idx_ff[SLOT_W-1:0]] = tgt_ff;
               rlen_in = rlen_ff + LEN_W'(1);
               if (kind_ff == KIND_TICK) state_in = ST_TICK_INS;
               else state_in = sched_q_ff ? ST_SCHED : ST_DONE;
            end else begin
               rdy_in[wr_ff[SLOT_W-1:0]] = rdy_ff[wr_ff[SLOT_W-1:0] - 1'b1];
               wr_in = wr_ff - LEN_W'(1);
            end
         end
         ST_DLY_SHIFT: begin
            // Pop ready head and push delayed head, one entry a cycle. The
            // target's stored priority is read on the first cycle.
            if (idx_ff == '0) rd_addr = tgt_ff;
            if (idx_ff == LEN_W'(1)) tprio_in = rd_prio;
            if (idx_ff + LEN_W'(1) < rlen_ff)
               rdy_in[idx_ff[SLOT_W-1:0]] = rdy_ff[idx_ff[SLOT_W-1:0] + 1'b1];
            if (idx_ff < dlen_ff)
               dly_in[dlen_ff[SLOT_W-1:0] - idx_ff[SLOT_W-1:0]] =
                  dly_ff[dlen_ff[SLOT_W-1:0] - idx_ff[SLOT_W-1:0] - 1'b1];
            idx_in = idx_ff + LEN_W'(1);
            if (idx_ff + LEN_W'(1) >= rlen_ff && idx_ff >= dlen_ff) begin
               dly_in[0] = tgt_ff;
               dlen_in   = dlen_ff + LEN_W'(1);
               rlen_in   = rlen_ff - LEN_W'(1);
               wr.we     = 1'b1;
               wr.addr   = tgt_ff;
               wr.st     = SS_DELAYED;
               wr.prio   = (idx_ff == LEN_W'(1)) ? rd_prio : tprio_ff;
               wr.dly    = dreq_ff;
               state_in  = ST_SCHED;
            end
         end
         ST_TICK_RD: begin
            rd_addr  = dly_ff[idx_ff[SLOT_W-1:0]];
            state_in = ST_TICK_CHK;
         end
         ST_TICK_CHK: begin
            rd_addr = dly_ff[idx_ff[SLOT_W-1:0]];
            wr.we   = 1'b1;
            wr.addr = dly_ff[idx_ff[SLOT_W-1:0]];
            wr.prio = rd_prio;
            wr.dly  = (rd_dly != 16'd0) ? rd_dly - 16'd1 : 16'd0;
            wr.st   = rd_st;
            if (rd_dly <= 16'd1) begin
               exp_in[ne_ff[SLOT_W-1:0]] = dly_ff[idx_ff[SLOT_W-1:0]];
               ne_in = ne_ff + LEN_W'(1);
            end else begin
               dly_in[wr_ff[SLOT_W-1:0]] = dly_ff[idx_ff[SLOT_W-1:0]];
               wr_in = wr_ff + LEN_W'(1);
            end
            idx_in = idx_ff + LEN_W'(1);
            if (idx_ff + LEN_W'(1) >= dlen_ff) begin
               dlen_in  = (rd_dly <= 16'd1) ? wr_ff : wr_ff + LEN_W'(1);
               idx_in   = '0;
               wr_in    = '0;
               state_in = ST_TICK_INS;
            end else begin
               state_in = ST_TICK_RD;
            end
         end
         ST_TICK_INS: begin
            // Reinsert expired tasks in order; the next one is always at the front.
            if (ne_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               tgt_in  = exp_ff[0];
               rd_addr = exp_ff[0];
               idx_in  = '0;
               for (int i = 0; i + 1 < TASK_SLOTS; i++) exp_in[i] = exp_ff[i + 1];
               ne_in    = ne_ff - LEN_W'(1);
               state_in = ST_INS_RD;
            end
         end
         ST_SCHED: begin
            if (started_ff && rlen_ff != '0 &&
                !(runv_ff && rdy_ff[0] == run_ff)) begin
               run_in    = rdy_ff[0];
               runv_in   = 1'b1;
               sw_cnt_in = sw_cnt_ff + 32'd1;
               swd_in    = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = rv_ff;
   assign rsp_current_valid = runv_ff;
   assign rsp_current_task  = runv_ff ? 4'(run_ff) : 4'd0;
   assign rsp_switched      = swd_ff;
   assign rsp_new_task_slot = 4'(nslot_ff);
   assign rsp_status        = stat_ff;
   assign rsp_switch_count  = sw_cnt_ff;
   assign rsp_tick_count    = tick_ff;

endmodule

>>> design/pts_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot table memory
// One entry per task slot holding state, priority and delay count; one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module pts_slot_mem (
   input  logic                     clock,
   input  pts_pkg::slot_wr_type     wr,
   input  logic [pts_pkg::SLOT_W-1:0] rd_addr,
   output logic [25:0]              rd_data
);
   import pts_pkg::*;

   logic [25:0] mem [TASK_SLOTS];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= {wr.st, wr.prio, wr.dly};
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives create, run, delay, tick and ISR words through the command port,
// predicts every result word from a model of the ready and delayed lists,
// and checks each result against the oldest prediction. The idle priority is
// rewritten between phases, down to both extremes.
// ----------------------------------------------------------------------------
module tb_top;
   import pts_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;
   localparam logic [2:0] KIND_UNUSED_A = 3'd6;
   localparam logic [2:0] KIND_UNUSED_B = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  prio;
      logic [15:0] dly;
      bit          drain;
   } cmd_word_type;

   typedef struct packed {
      logic        current_valid;
      logic [3:0]  current_task;
      logic        switched;
      logic [3:0]  new_task_slot;
      logic [1:0]  status;
      logic [31:0] switch_count;
      logic [31:0] tick_count;
   } sched_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_priority_req = '0;
   logic [15:0] req_delay_ticks = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_idle_priority = '0;
   logic        rsp_valid;
   sched_word_type got_word;

   cmd_word_type   cmd_pending[$];
   sched_word_type sched_expected[$];
   int          mismatches = 0;
   bit          word_taken = 1'b0;
   int          gap_left = 0;

   // Scheduler state as the testbench predicts it.
   logic [7:0]  idle_prio;
   logic [1:0]  slot_st[TASK_SLOTS];
   logic [7:0]  slot_pr[TASK_SLOTS];
   logic [15:0] slot_wait[TASK_SLOTS];
   logic [3:0]  ready_list[TASK_SLOTS];
   int          ready_len;
   logic [3:0]  delay_list[TASK_SLOTS];
   int          delay_len;
   logic [3:0]  run_slot;
   bit          run_valid;
   bit          sched_on;
   logic [7:0]  nest;
   logic [31:0] switch_total;
   logic [31:0] tick_total;

   priority_task_scheduler_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_priority_req(req_priority_req),
      .req_delay_ticks(req_delay_ticks),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_idle_priority(csr_idle_priority),
      .rsp_valid(rsp_valid),
      .rsp_current_valid(got_word.current_valid),
      .rsp_current_task(got_word.current_task),
      .rsp_switched(got_word.switched),
      .rsp_new_task_slot(got_word.new_task_slot),
      .rsp_status(got_word.status),
      .rsp_switch_count(got_word.switch_count),
      .rsp_tick_count(got_word.tick_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void sched_reset();
      idle_prio = IDLE_PRIO_RESET;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_st[i] = SS_FREE;
         slot_pr[i] = '0;
         slot_wait[i] = '0;
         ready_list[i] = '0;
         delay_list[i] = '0;
      end
      slot_st[IDLE_SLOT] = SS_READY;
      slot_pr[IDLE_SLOT] = idle_prio;
      ready_len = 1;
      delay_len = 0;
      run_slot = '0;
      run_valid = 1'b0;
      sched_on = 1'b0;
      nest = '0;
      switch_total = '0;
      tick_total = '0;
   endfunction

   // New entry goes ahead of equal priorities but never behind the idle tail.
   function automatic void ready_put(logic [3:0] s);
      int pos;
      if (ready_len == 0 || ready_len >= TASK_SLOTS) return;
      pos = ready_len - 1;
      for (int i = 0; i + 1 < ready_len; i++) begin
         if (slot_pr[ready_list[i]] >= slot_pr[s]) begin
            pos = i;
            break;
         end
      end
      for (int i = ready_len; i > pos; i--) ready_list[i] = ready_list[i-1];
      ready_list[pos] = s;
      ready_len++;
      slot_st[s] = SS_READY;
   endfunction

   function automatic bit dispatch();
      if (!sched_on || ready_len == 0) return 1'b0;
      if (run_valid && ready_list[0] == run_slot) return 1'b0;
      run_slot = ready_list[0];
      run_valid = 1'b1;
      switch_total++;
      return 1'b1;
   endfunction

   function automatic sched_word_type sched_predict(cmd_word_type c);
      sched_word_type w;
      bit sw;
      int free_slot;
      int kept;
      int n_exp;
      logic [3:0] t;
      logic [3:0] expired[TASK_SLOTS];
      sw = 1'b0;
      w.new_task_slot = '0;
      w.status = STAT_OK;
      case (c.kind)
         KIND_CREATE: begin
            free_slot = TASK_SLOTS;
            if (c.prio >= idle_prio) w.status = STAT_BADPRIO;
            else begin
               for (int i = 1; i < TASK_SLOTS; i++)
                  if (slot_st[i] == SS_FREE) begin
                     free_slot = i;
                     break;
                  end
               if (free_slot >= TASK_SLOTS) w.status = STAT_NO_SLOT;
               else begin
                  slot_pr[free_slot] = c.prio;
                  slot_wait[free_slot] = '0;
                  ready_put(4'(free_slot));
                  w.new_task_slot = 4'(free_slot);
                  sw = dispatch();
               end
            end
         end
         KIND_RUN: begin
            sched_on = 1'b1;
            sw = dispatch();
         end
         KIND_DELAY: begin
            if (ready_len <= 1 || ready_list[0] == IDLE_SLOT || delay_len >= TASK_SLOTS)
               w.status = STAT_IDLEDLY;
            else begin
               t = ready_list[0];
               for (int i = 0; i + 1 < ready_len; i++) ready_list[i] = ready_list[i+1];
               ready_len--;
               for (int i = delay_len; i > 0; i--) delay_list[i] = delay_list[i-1];
               delay_list[0] = t;
               delay_len++;
               slot_st[t] = SS_DELAYED;
               slot_wait[t] = (c.dly == 0) ? 16'd1 : c.dly;
               sw = dispatch();
            end
         end
         KIND_TICK: begin
            // Count every delayed task down; expired ones rejoin in list order.
            tick_total++;
            kept = 0;
            n_exp = 0;
            for (int i = 0; i < delay_len; i++) begin
               t = delay_list[i];
               if (slot_wait[t] > 0) slot_wait[t]--;
               if (slot_wait[t] == 0) expired[n_exp++] = t;
               else delay_list[kept++] = t;
            end
            delay_len = kept;
            for (int i = 0; i < n_exp; i++) ready_put(expired[i]);
         end
         KIND_ISR_IN: if (nest < 8'd255) nest++;
         KIND_ISR_EX: begin
            if (nest > 0) begin
               nest--;
               if (nest == 0) sw = dispatch();
            end
         end
         default: ;
      endcase
      w.current_valid = run_valid;
      w.current_task = run_valid ? run_slot : 4'd0;
      w.switched = sw;
      w.switch_count = switch_total;
      w.tick_count = tick_total;
      return w;
   endfunction

   // Monitor: check result words, and predict each command word on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         sched_reset();
         word_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (sched_expected.size() == 0) begin
               $display("%0t: unexpected result word %p", $realtime, got_word);
               mismatches++;
            end else begin
               if (got_word !== sched_expected[0]) begin
                  $display("%0t: expected %p, got %p", $realtime, sched_expected[0],
                           got_word);
                  mismatches++;
               end
               void'(sched_expected.pop_front());
            end
         end
         if (csr_valid && csr_ready) begin
            idle_prio = csr_idle_priority;
            slot_pr[IDLE_SLOT] = csr_idle_priority;
         end
         if (start && !busy)
            sched_expected.push_back(sched_predict('{req_kind, req_priority_req,
                                                     req_delay_ticks, 1'b0}));
         word_taken <= start && !busy;
      end
   end

   // Driver: present one command word at a time with random gaps.
   always @(negedge clock) begin
      cmd_word_type c;
      logic next_start;
      int r;
      next_start = 1'b0;
      if (!reset) begin
         if (start && !word_taken) next_start = 1'b1;
         else begin
            if (start && word_taken) begin
               r = $urandom_range(0, 99);
               gap_left = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 60);
            end
            if (gap_left > 0) gap_left--;
            else if (cmd_pending.size() > 0 &&
                     !(cmd_pending[0].drain && sched_expected.size() != 0)) begin
               c = cmd_pending.pop_front();
               req_kind <= c.kind;
               req_priority_req <= c.prio;
               req_delay_ticks <= c.dly;
               next_start = 1'b1;
            end
         end
      end
      start <= next_start;
   end

   // Watchdog: cycles in which nothing at all is accepted.
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         stall_cycles <= 0;
      else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   task automatic push_cmd(logic [2:0] k, logic [7:0] p, logic [15:0] d);
      cmd_pending.push_back('{k, p, d, 1'b0});
   endtask

   task automatic wait_quiet();
      wait (cmd_pending.size() == 0 && sched_expected.size() == 0 && !start);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_idle_prio(logic [7:0] v);
      @(negedge clock);
      csr_idle_priority <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random phase: mostly well-formed traffic around the current idle level.
   task automatic random_phase(int count, logic [7:0] idle_now);
      int r;
      logic [7:0] p;
      logic [15:0] d;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) < 8 && idle_now > 0)
            p = 8'($urandom_range(0, idle_now - 1));
         else p = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 19) == 0) d = 16'($urandom_range(0, 65535));
         else d = 16'($urandom_range(0, 6));
         if (r < 22) push_cmd(KIND_CREATE, p, d);
         else if (r < 44) push_cmd(KIND_DELAY, p, d);
         else if (r < 74) push_cmd(KIND_TICK, p, d);
         else if (r < 84) push_cmd(KIND_ISR_IN, p, d);
         else if (r < 95) push_cmd(KIND_ISR_EX, p, d);
         else if (r < 98) push_cmd(KIND_RUN, p, d);
         else push_cmd($urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B, p, d);
      end
   endtask

   initial begin
      logic [7:0] v;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: work before start, rejections, extremes, unused kinds.
      push_cmd(KIND_DELAY, 8'd0, 16'd5);
      push_cmd(KIND_ISR_EX, 8'd0, 16'd0);
      push_cmd(KIND_CREATE, 8'd100, 16'd0);
      push_cmd(KIND_CREATE, 8'd255, 16'hffff);
      push_cmd(KIND_CREATE, 8'd99, 16'd0);
      push_cmd(KIND_CREATE, 8'd0, 16'd0);
      push_cmd(KIND_DELAY, 8'd0, 16'd0);
      push_cmd(KIND_TICK, 8'd0, 16'd0);
      push_cmd(KIND_RUN, 8'd0, 16'd0);
      push_cmd(KIND_RUN, 8'hff, 16'hffff);
      push_cmd(KIND_DELAY, 8'd0, 16'hffff);
      push_cmd(KIND_DELAY, 8'd0, 16'd1);
      push_cmd(KIND_ISR_IN, 8'd0, 16'd0);
      push_cmd(KIND_CREATE, 8'd50, 16'd0);
      push_cmd(KIND_ISR_EX, 8'd0, 16'd0);
      push_cmd(KIND_UNUSED_A, 8'hff, 16'hffff);
      push_cmd(KIND_UNUSED_B, 8'd0, 16'd0);
      for (int i = 0; i < 15; i++) push_cmd(KIND_CREATE, 8'(i * 6), 16'd0);
      cmd_pending.push_back('{KIND_TICK, 8'd0, 16'd0, 1'b1});
      wait_quiet();

      // Nesting saturates at the top and unwinds to a reschedule.
      for (int i = 0; i < 258; i++) push_cmd(KIND_ISR_IN, 8'd0, 16'd0);
      for (int i = 0; i < 256; i++) push_cmd(KIND_ISR_EX, 8'd0, 16'd0);
      wait_quiet();

      random_phase(100, IDLE_PRIO_RESET);
      wait_quiet();
      write_idle_prio(8'd255);
      random_phase(80, 8'd255);
      wait_quiet();
      write_idle_prio(8'd0);
      random_phase(40, 8'd0);
      wait_quiet();
      write_idle_prio(8'd1);
      random_phase(60, 8'd1);
      wait_quiet();
      v = 8'($urandom_range(2, 254));
      write_idle_prio(v);
      random_phase(75, v);
      cmd_pending.push_back('{KIND_RUN, 8'd0, 16'd0, 1'b1});
      random_phase(75, v);
      wait_quiet();
      write_idle_prio(IDLE_PRIO_RESET);
      random_phase(70, IDLE_PRIO_RESET);
      wait_quiet();

      if (mismatches == 0 && sched_expected.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
design/pts_pkg.sv
design/pts_slot_mem.sv
design/priority_task_scheduler_unit.sv
tb/tb_top.sv
